[design/kalman_filter_2state_scalar_macros.svh]
// Assertion macros shared by the filter RTL.
`ifndef KALMAN_FILTER_2STATE_SCALAR_MACROS_SVH
`define KALMAN_FILTER_2STATE_SCALAR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, clocked on i_clk and held off during reset.
`define KF2_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("kf2 assertion failed");
// Next-cycle implication.
`define KF2_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("kf2 assertion failed");
`else
`define KF2_ASSERT_NOW(label, pre, post)
`define KF2_ASSERT_NEXT(label, pre, post)
`endif
`endif

[design/kf2_pkg.sv]
// ----------------------------------------------------------------------------
// kf2_pkg
// Types, codes and the microprogram of the two-state Kalman filter.
// ----------------------------------------------------------------------------
package kf2_pkg;

    localparam int ACC_W = 66;
    localparam int PC_W  = 6;

    typedef logic [PC_W-1:0] t_pc;
    typedef logic [1:0]      t_status;

    localparam t_status STAT_OK   = 2'd0;
    localparam t_status STAT_SAT  = 2'd1;
    localparam t_status STAT_SKIP = 2'd2;

    typedef enum logic [2:0] {
        REG_TRANS_A, REG_TRANS_B, REG_TRANS_C, REG_TRANS_D,
        REG_OBS_POS, REG_OBS_VEL, REG_MEAS_NOISE, REG_INIT_VAR
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] trans_a;
        logic signed [31:0] trans_b;
        logic signed [31:0] trans_c;
        logic signed [31:0] trans_d;
        logic signed [31:0] obs_pos;
        logic signed [31:0] obs_vel;
        logic        [30:0] meas_noise;
        logic        [30:0] init_var;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_MAC, S_DIV, S_DONE
    } t_state;

    typedef enum logic [1:0] { K_MAC, K_DIV, K_CHECK, K_END } t_kind;

    typedef enum logic [5:0] {
        OP_ZERO, OP_ONE, OP_Z, OP_X0, OP_X1,
        OP_P00, OP_P01, OP_P10, OP_P11,
        OP_HX, OP_Y, OP_A0, OP_A1, OP_S, OP_K0, OP_K1,
        OP_M00, OP_M01, OP_M10, OP_M11,
        OP_T00, OP_T01, OP_T10, OP_T11,
        OP_TA, OP_TB, OP_TC, OP_TD, OP_H0, OP_H1, OP_R
    } t_opd;

    typedef struct packed {
        t_kind kind;
        t_opd  a1;
        t_opd  b1;
        logic  n1;
        t_opd  a2;
        t_opd  b2;
        logic  n2;
        t_opd  add;
        t_opd  dst;
    } t_uop;

    localparam t_pc PC_PREDICT = t_pc'(22);

    // MAC and divider results, with saturation flag, handed back to the sequencer
    typedef struct packed {
        logic               done;
        logic               sat;
        logic signed [31:0] value;
    } t_res;

    function automatic t_uop mk(input t_kind k, input t_opd d, input t_opd ad,
                                input t_opd a1, input t_opd b1, input logic n1,
                                input t_opd a2, input t_opd b2, input logic n2);
        t_uop u;
        u.kind = k; u.dst = d; u.add = ad;
        u.a1 = a1; u.b1 = b1; u.n1 = n1;
        u.a2 = a2; u.b2 = b2; u.n2 = n2;
        return u;
    endfunction

    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        case (pc)
            6'd0:  u = mk(K_MAC, OP_HX, OP_ZERO, OP_H0, OP_X0, 0, OP_H1, OP_X1, 0);
            6'd1:  u = mk(K_MAC, OP_Y, OP_ZERO, OP_Z, OP_ONE, 0, OP_HX, OP_ONE, 1);
            6'd2:  u = mk(K_MAC, OP_A0, OP_ZERO, OP_P00, OP_H0, 0, OP_P01, OP_H1, 0);
            6'd3:  u = mk(K_MAC, OP_A1, OP_ZERO, OP_P10, OP_H0, 0, OP_P11, OP_H1, 0);
            6'd4:  u = mk(K_MAC, OP_S, OP_R, OP_H0, OP_A0, 0, OP_H1, OP_A1, 0);
            6'd5:  u = mk(K_CHECK, OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, 0,
                          OP_ZERO, OP_ZERO, 0);
            6'd6:  u = mk(K_DIV, OP_K0, OP_ZERO, OP_A0, OP_ZERO, 0, OP_ZERO, OP_ZERO, 0);
            6'd7:  u = mk(K_DIV, OP_K1, OP_ZERO, OP_A1, OP_ZERO, 0, OP_ZERO, OP_ZERO, 0);
            6'd8:  u = mk(K_MAC, OP_M00, OP_ONE, OP_K0, OP_H0, 1, OP_ZERO, OP_ZERO, 0);
            6'd9:  u = mk(K_MAC, OP_M01, OP_ZERO, OP_K0, OP_H1, 1, OP_ZERO, OP_ZERO, 0);
            6'd10: u = mk(K_MAC, OP_M10, OP_ZERO, OP_K1, OP_H0, 1, OP_ZERO, OP_ZERO, 0);
            6'd11: u = mk(K_MAC, OP_M11, OP_ONE, OP_K1, OP_H1, 1, OP_ZERO, OP_ZERO, 0);
            6'd12: u = mk(K_MAC, OP_X0, OP_X0, OP_K0, OP_Y, 0, OP_ZERO, OP_ZERO, 0);
            6'd13: u = mk(K_MAC, OP_X1, OP_X1, OP_K1, OP_Y, 0, OP_ZERO, OP_ZERO, 0);
            6'd14: u = mk(K_MAC, OP_T00, OP_ZERO, OP_M00, OP_P00, 0, OP_M01, OP_P10, 0);
            6'd15: u = mk(K_MAC, OP_T01, OP_ZERO, OP_M00, OP_P01, 0, OP_M01, OP_P11, 0);
            6'd16: u = mk(K_MAC, OP_T10, OP_ZERO, OP_M10, OP_P00, 0, OP_M11, OP_P10, 0);
            6'd17: u = mk(K_MAC, OP_T11, OP_ZERO, OP_M10, OP_P01, 0, OP_M11, OP_P11, 0);
            6'd18: u = mk(K_MAC, OP_P00, OP_ZERO, OP_T00, OP_ONE, 0, OP_ZERO, OP_ZERO, 0);
            6'd19: u = mk(K_MAC, OP_P01, OP_ZERO, OP_T01, OP_ONE, 0, OP_ZERO, OP_ZERO, 0);
            6'd20: u = mk(K_MAC, OP_P10, OP_ZERO, OP_T10, OP_ONE, 0, OP_ZERO, OP_ZERO, 0);
            6'd21: u = mk(K_MAC, OP_P11, OP_ZERO, OP_T11, OP_ONE, 0, OP_ZERO, OP_ZERO, 0);
            6'd22: u = mk(K_MAC, OP_HX, OP_ZERO, OP_TA, OP_X0, 0, OP_TB, OP_X1, 0);
            6'd23: u = mk(K_MAC, OP_Y, OP_ZERO, OP_TC, OP_X0, 0, OP_TD, OP_X1, 0);
            6'd24: u = mk(K_MAC, OP_X0, OP_ZERO, OP_HX, OP_ONE, 0, OP_ZERO, OP_ZERO, 0);
            6'd25: u = mk(K_MAC, OP_X1, OP_ZERO, OP_Y, OP_ONE, 0, OP_ZERO, OP_ZERO, 0);
            6'd26: u = mk(K_MAC, OP_T00, OP_ZERO, OP_TA, OP_P00, 0, OP_TB, OP_P10, 0);
            6'd27: u = mk(K_MAC, OP_T01, OP_ZERO, OP_TA, OP_P01, 0, OP_TB, OP_P11, 0);
            6'd28: u = mk(K_MAC, OP_T10, OP_ZERO, OP_TC, OP_P00, 0, OP_TD, OP_P10, 0);
            6'd29: u = mk(K_MAC, OP_T11, OP_ZERO, OP_TC, OP_P01, 0, OP_TD, OP_P11, 0);
            6'd30: u = mk(K_MAC, OP_P00, OP_ZERO, OP_T00, OP_TA, 0, OP_T01, OP_TB, 0);
            6'd31: u = mk(K_MAC, OP_P01, OP_ZERO, OP_T00, OP_TC, 0, OP_T01, OP_TD, 0);
            6'd32: u = mk(K_MAC, OP_P10, OP_ZERO, OP_T10, OP_TA, 0, OP_T11, OP_TB, 0);
            6'd33: u = mk(K_MAC, OP_P11, OP_ZERO, OP_T10, OP_TC, 0, OP_T11, OP_TD, 0);
            default: u = mk(K_END, OP_ZERO, OP_ZERO, OP_ZERO, OP_ZERO, 0,
                            OP_ZERO, OP_ZERO, 0);
        endcase
        return u;
    endfunction

    // clamp a wide accumulator to 32 bit signed; top bit flags a clamp
    function automatic logic [32:0] sat_acc(input logic signed [ACC_W-1:0] v);
        logic [32:0] r;
        if (v > ACC_W'(64'sd2147483647)) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -ACC_W'(64'sd2147483648)) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

[design/kf2_in_if.sv]
// ----------------------------------------------------------------------------
// kf2_in_if
// Measurement channel: valid/ready with measurement and restart.
// ----------------------------------------------------------------------------
interface kf2_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] meas_value;
    logic               restart;

    modport source (output valid, output meas_value, output restart, input ready);
    modport sink   (input valid, input meas_value, input restart, output ready);
endinterface

[design/kf2_out_if.sv]
// ----------------------------------------------------------------------------
// kf2_out_if
// Result channel: valid/ready with estimate, covariance and status.
// ----------------------------------------------------------------------------
interface kf2_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] est_position;
    logic signed [31:0] est_velocity;
    logic signed [31:0] var_pp;
    logic signed [31:0] var_pv;
    logic signed [31:0] var_vp;
    logic signed [31:0] var_vv;
    logic        [1:0]  status;

    modport source (output valid, output est_position, output est_velocity,
                    output var_pp, output var_pv, output var_vp, output var_vv,
                    output status, input ready);
    modport sink   (input valid, input est_position, input est_velocity,
                    input var_pp, input var_pv, input var_vp, input var_vv,
                    input status, output ready);
endinterface

[design/kf2_cfg.sv]
// ----------------------------------------------------------------------------
// kf2_cfg
// APB register bank for the transition, observation, noise and initial-variance settings.
// ----------------------------------------------------------------------------
module kf2_cfg import kf2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);
    localparam logic [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr;

    assign idx    = t_reg_idx'(paddr[4:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trans_a    <= ONE;
            r_cfg.trans_b    <= ONE;
            r_cfg.trans_c    <= '0;
            r_cfg.trans_d    <= ONE;
            r_cfg.obs_pos    <= ONE;
            r_cfg.obs_vel    <= '0;
            r_cfg.meas_noise <= ONE[30:0];
            r_cfg.init_var   <= 31'(64'd100 << FRAC_BITS);
        end else if (wr) begin
            case (idx)
                REG_TRANS_A:    r_cfg.trans_a    <= pwdata;
                REG_TRANS_B:    r_cfg.trans_b    <= pwdata;
                REG_TRANS_C:    r_cfg.trans_c    <= pwdata;
                REG_TRANS_D:    r_cfg.trans_d    <= pwdata;
                REG_OBS_POS:    r_cfg.obs_pos    <= pwdata;
                REG_OBS_VEL:    r_cfg.obs_vel    <= pwdata;
                REG_MEAS_NOISE: r_cfg.meas_noise <= pwdata[30:0];
                REG_INIT_VAR:   r_cfg.init_var   <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TRANS_A:    prdata = r_cfg.trans_a;
            REG_TRANS_B:    prdata = r_cfg.trans_b;
            REG_TRANS_C:    prdata = r_cfg.trans_c;
            REG_TRANS_D:    prdata = r_cfg.trans_d;
            REG_OBS_POS:    prdata = r_cfg.obs_pos;
            REG_OBS_VEL:    prdata = r_cfg.obs_vel;
            REG_MEAS_NOISE: prdata = {1'b0, r_cfg.meas_noise};
            REG_INIT_VAR:   prdata = {1'b0, r_cfg.init_var};
            default:        prdata = '0;
        endcase
    end
endmodule

[design/kf2_mac.sv]
// ----------------------------------------------------------------------------
// kf2_mac
// Shared multiplier: add term plus or minus two floored fixed-point products, clamped.
// ----------------------------------------------------------------------------
module kf2_mac import kf2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_a1,
    input  logic signed [31:0] i_b1,
    input  logic               i_n1,
    input  logic signed [31:0] i_a2,
    input  logic signed [31:0] i_b2,
    input  logic               i_n2,
    input  logic signed [31:0] i_add,
    output t_res               o_res
);
    logic        [1:0]       r_ph;
    logic signed [63:0]      r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] term;
    logic        [32:0]      sat;

    // arithmetic shift floors toward minus infinity
    assign term = ACC_W'(r_prod >>> FRAC_BITS);
    assign sat  = sat_acc(r_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= 2'd0;
        end else begin
            case (r_ph)
                2'd0:    r_ph <= i_start ? 2'd1 : 2'd0;
                default: r_ph <= r_ph + 2'd1;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_ph)
            2'd0: begin
                r_prod <= i_a1 * i_b1;
            end
            2'd1: begin
                r_acc  <= i_n1 ? ACC_W'(i_add) - term : ACC_W'(i_add) + term;
                r_prod <= i_a2 * i_b2;
            end
            2'd2: begin
                r_acc  <= i_n2 ? r_acc - term : r_acc + term;
            end
            default: ;
        endcase
    end

    assign o_res.done  = (r_ph == 2'd3);
    assign o_res.sat   = sat[32];
    assign o_res.value = sat[31:0];
endmodule

[design/kf2_div.sv]
// ----------------------------------------------------------------------------
// kf2_div
// Restoring divider for the gain: (a << FRAC_BITS) / s, s positive, clamped.
// ----------------------------------------------------------------------------
module kf2_div import kf2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output t_res               o_res
);
    localparam int DW  = 32 + FRAC_BITS;
    localparam int CW  = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic [32:0]   r_rem;
    logic [DW-1:0] r_quo;
    logic [31:0]   mag;
    logic [33:0]   trial;
    logic [33:0]   diff;

    assign mag   = i_num[31] ? 32'(-i_num) : i_num;
    assign trial = {r_rem, r_quo[DW-1]};
    assign diff  = trial - {2'b00, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (o_res.done) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= '0;
            r_neg <= i_num[31];
            r_rem <= '0;
            r_quo <= {mag, FRAC_BITS'(0)};
        end else if (r_busy && r_cnt != CW'(DW)) begin
            r_cnt <= r_cnt + CW'(1);
            if (!diff[33]) begin
                r_rem <= diff[32:0];
                r_quo <= {r_quo[DW-2:0], 1'b1};
            end else begin
                r_rem <= trial[32:0];
                r_quo <= {r_quo[DW-2:0], 1'b0};
            end
        end
    end

    // clamp the signed quotient to 32 bits
    always_comb begin
        o_res.done = r_busy && (r_cnt == CW'(DW));
        if (!r_neg && r_quo > DW'(64'h7fff_ffff)) begin
            o_res.sat   = 1'b1;
            o_res.value = 32'h7fff_ffff;
        end else if (r_neg && r_quo > DW'(64'h8000_0000)) begin
            o_res.sat   = 1'b1;
            o_res.value = 32'h8000_0000;
        end else begin
            o_res.sat   = 1'b0;
            o_res.value = r_neg ? 32'(-r_quo[31:0]) : r_quo[31:0];
        end
    end
endmodule

[design/kalman_filter_2state_scalar.sv]
// Flow: a restart goes from acceptance straight to the result; a measurement runs
//   the microprogram, which skips the update and goes straight to prediction
//   when S is not positive; a stalled result adds its wait.
// Throughput: one transaction at a time, worked through the shared multiplier
//   and the bit-serial gain divider.
// Reset: synchronous active low; x = 0, P = diag(100.0), registers to defaults.
// ----------------------------------------------------------------------------
// kalman_filter_2state_scalar
// Two-state Kalman filter, update then predict, microcoded over one MAC unit and a divider.
// ----------------------------------------------------------------------------
`include "kalman_filter_2state_scalar_macros.svh"
module kalman_filter_2state_scalar import kf2_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    kf2_in_if.sink      i_in,
    kf2_out_if.source   o_out
);
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    t_cfg   cfg;
    t_state r_state, n_state;
    t_pc    r_pc;
    t_uop   uop;
    t_res   mac_res, div_res, wr_res;

    // working set of the filter: state, covariance and step temporaries
    logic signed [31:0] r_z, r_x0, r_x1, r_p00, r_p01, r_p10, r_p11;
    logic signed [31:0] r_hx, r_y, r_a0, r_a1, r_s, r_k0, r_k1;
    logic signed [31:0] r_m00, r_m01, r_m10, r_m11, r_t00, r_t01, r_t10, r_t11;
    logic signed [31:0] op_a1, op_b1, op_a2, op_b2, op_add;
    logic               r_sat, r_skip, r_ov;
    logic               in_acc, mac_start, div_start, wr_en, out_load;

    kf2_cfg #(.FRAC_BITS(FRAC_BITS)) u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg)
    );

    function automatic logic signed [31:0] rd(input t_opd sel);
        logic signed [31:0] v;
        case (sel)
            OP_ONE: v = ONE;      OP_Z:   v = r_z;
            OP_X0:  v = r_x0;     OP_X1:  v = r_x1;
            OP_P00: v = r_p00;    OP_P01: v = r_p01;
            OP_P10: v = r_p10;    OP_P11: v = r_p11;
            OP_HX:  v = r_hx;     OP_Y:   v = r_y;
            OP_A0:  v = r_a0;     OP_A1:  v = r_a1;
            OP_S:   v = r_s;      OP_K0:  v = r_k0;   OP_K1:  v = r_k1;
            OP_M00: v = r_m00;    OP_M01: v = r_m01;
            OP_M10: v = r_m10;    OP_M11: v = r_m11;
            OP_T00: v = r_t00;    OP_T01: v = r_t01;
            OP_T10: v = r_t10;    OP_T11: v = r_t11;
            OP_TA:  v = cfg.trans_a;   OP_TB: v = cfg.trans_b;
            OP_TC:  v = cfg.trans_c;   OP_TD: v = cfg.trans_d;
            OP_H0:  v = cfg.obs_pos;   OP_H1: v = cfg.obs_vel;
            OP_R:   v = {1'b0, cfg.meas_noise};
            default: v = '0;
        endcase
        return v;
    endfunction

    assign uop = ucode(r_pc);

    // operand select for the shared units
    always_comb begin
        op_a1  = rd(uop.a1);
        op_b1  = rd(uop.b1);
        op_a2  = rd(uop.a2);
        op_b2  = rd(uop.b2);
        op_add = rd(uop.add);
    end

    kf2_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk, .i_rst_n, .i_start(mac_start),
        .i_a1(op_a1), .i_b1(op_b1), .i_n1(uop.n1),
        .i_a2(op_a2), .i_b2(op_b2), .i_n2(uop.n2),
        .i_add(op_add), .o_res(mac_res)
    );

    kf2_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk, .i_rst_n, .i_start(div_start),
        .i_num(op_a1), .i_den(r_s), .o_res(div_res)
    );

    assign in_acc = i_in.valid && i_in.ready;
    assign wr_res = (r_state == S_DIV) ? div_res : mac_res;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = i_in.restart ? S_DONE : S_ISSUE;
            end
            S_ISSUE: begin
                case (uop.kind)
                    K_MAC:   n_state = S_MAC;
                    K_DIV:   n_state = S_DIV;
                    K_CHECK: n_state = S_ISSUE;
                    K_END:   n_state = S_DONE;
                    default: n_state = S_IDLE;
                endcase
            end
            S_MAC:  if (mac_res.done) n_state = S_ISSUE;
            S_DIV:  if (div_res.done) n_state = S_ISSUE;
            S_DONE: if (!r_ov || o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        i_in.ready = (r_state == S_IDLE);
        mac_start  = (r_state == S_ISSUE) && (uop.kind == K_MAC);
        div_start  = (r_state == S_ISSUE) && (uop.kind == K_DIV);
        wr_en      = ((r_state == S_MAC) && mac_res.done) ||
                     ((r_state == S_DIV) && div_res.done);
        out_load   = (r_state == S_DONE) && (!r_ov || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_x0    <= '0;
            r_x1    <= '0;
            r_p00   <= 32'(64'd100 << FRAC_BITS);
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= 32'(64'd100 << FRAC_BITS);
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
            if (in_acc && i_in.restart) begin
                // restart: clear the estimate and off-diagonal terms, reload the diagonal
                r_x0  <= '0;
                r_x1  <= '0;
                r_p00 <= {1'b0, cfg.init_var};
                r_p01 <= '0;
                r_p10 <= '0;
                r_p11 <= {1'b0, cfg.init_var};
            end else if (wr_en) begin
                case (uop.dst)
                    OP_X0:  r_x0  <= wr_res.value;
                    OP_X1:  r_x1  <= wr_res.value;
                    OP_P00: r_p00 <= wr_res.value;
                    OP_P01: r_p01 <= wr_res.value;
                    OP_P10: r_p10 <= wr_res.value;
                    OP_P11: r_p11 <= wr_res.value;
                    default: ;
                endcase
            end
        end
    end

    // sequencer bookkeeping and temporaries
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_z    <= i_in.meas_value;
            r_pc   <= '0;
            r_sat  <= 1'b0;
            r_skip <= 1'b0;
        end else if (r_state == S_ISSUE && uop.kind == K_CHECK) begin
            // non-positive S: drop the update, go straight to prediction
            if (r_s <= 0) begin
                r_skip <= 1'b1;
                r_pc   <= PC_PREDICT;
            end else begin
                r_pc   <= r_pc + t_pc'(1);
            end
        end else if (wr_en) begin
            r_pc  <= r_pc + t_pc'(1);
            r_sat <= r_sat | wr_res.sat;
            case (uop.dst)
                OP_HX:  r_hx  <= wr_res.value;
                OP_Y:   r_y   <= wr_res.value;
                OP_A0:  r_a0  <= wr_res.value;
                OP_A1:  r_a1  <= wr_res.value;
                OP_S:   r_s   <= wr_res.value;
                OP_K0:  r_k0  <= wr_res.value;
                OP_K1:  r_k1  <= wr_res.value;
                OP_M00: r_m00 <= wr_res.value;
                OP_M01: r_m01 <= wr_res.value;
                OP_M10: r_m10 <= wr_res.value;
                OP_M11: r_m11 <= wr_res.value;
                OP_T00: r_t00 <= wr_res.value;
                OP_T01: r_t01 <= wr_res.value;
                OP_T10: r_t10 <= wr_res.value;
                OP_T11: r_t11 <= wr_res.value;
                default: ;
            endcase
        end
    end

    // output register: hold the transaction until taken
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out.est_position <= r_x0;
            o_out.est_velocity <= r_x1;
            o_out.var_pp       <= r_p00;
            o_out.var_pv       <= r_p01;
            o_out.var_vp       <= r_p10;
            o_out.var_vv       <= r_p11;
            o_out.status       <= r_skip ? STAT_SKIP : (r_sat ? STAT_SAT : STAT_OK);
        end
    end

    assign o_out.valid = r_ov;

    `KF2_ASSERT_NOW(a_mac_done_in_mac, mac_res.done, r_state == S_MAC)
    `KF2_ASSERT_NOW(a_div_done_in_div, div_res.done, r_state == S_DIV)
    `KF2_ASSERT_NOW(a_status_code, r_ov, o_out.status != 2'd3)
    `KF2_ASSERT_NEXT(a_start_busy, mac_start, r_state == S_MAC && !mac_res.done)
endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives measurements and restarts into the two-state filter, programmes the
// registers over APB between phases, and checks every result transaction
// against a fixed-point predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;
    import kf2_pkg::*;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] p00;
        logic signed [31:0] p01;
        logic signed [31:0] p10;
        logic signed [31:0] p11;
        logic [1:0]         status;
    } t_estimate;

    localparam int FRAC = 16;
    localparam longint ONE = 64'sd1 << FRAC;

    // ------------------------------------------------------------------
    // Scoreboard: filter predictor and queue of expected estimates
    // ------------------------------------------------------------------
    class kf_scoreboard;
        longint fa, fb, fc, fd, h0, h1, rn, iv;
        longint x0, x1, c00, c01, c10, c11;
        bit sat;
        t_estimate pending[$];
        int errors;

        function new();
            fa = ONE; fb = ONE; fc = 0; fd = ONE; h0 = ONE; h1 = 0;
            rn = ONE; iv = 100 * ONE;
            x0 = 0; x1 = 0; c00 = 100 * ONE; c01 = 0; c10 = 0; c11 = 100 * ONE;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_TRANS_A:    fa = longint'($signed(v));
                REG_TRANS_B:    fb = longint'($signed(v));
                REG_TRANS_C:    fc = longint'($signed(v));
                REG_TRANS_D:    fd = longint'($signed(v));
                REG_OBS_POS:    h0 = longint'($signed(v));
                REG_OBS_VEL:    h1 = longint'($signed(v));
                REG_MEAS_NOISE: rn = longint'({33'd0, v[30:0]});
                default:        iv = longint'({33'd0, v[30:0]});
            endcase
        endfunction

        // arithmetic shift floors, as the datapath does
        function longint fmul(longint a, longint b);
            return (a * b) >>> FRAC;
        endfunction

        function longint clamp(longint v);
            if (v > 64'sd2147483647) begin
                sat = 1; return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1; return -64'sd2147483648;
            end
            return v;
        endfunction

        // note an accepted measurement or restart and queue its estimate
        function void note_input(logic signed [31:0] z, logic rst);
            longint hx, y, a0, a1, s, k0, k1, m00, m01, m10, m11;
            longint n00, n01, n10, n11, t00, t01, t10, t11, p, v;
            t_estimate e;
            logic [1:0] st;
            st = STAT_OK;
            sat = 0;
            if (rst) begin
                x0 = 0; x1 = 0; c00 = iv; c01 = 0; c10 = 0; c11 = iv;
            end else begin
                hx = clamp(fmul(h0, x0) + fmul(h1, x1));
                y = clamp(longint'(z) - hx);
                a0 = clamp(fmul(c00, h0) + fmul(c01, h1));
                a1 = clamp(fmul(c10, h0) + fmul(c11, h1));
                s = clamp(fmul(h0, a0) + fmul(h1, a1) + rn);
                if (s <= 0) begin
                    st = STAT_SKIP;
                end else begin
                    k0 = clamp((a0 * ONE) / s);
                    k1 = clamp((a1 * ONE) / s);
                    m00 = clamp(ONE - fmul(k0, h0));
                    m01 = clamp(-fmul(k0, h1));
                    m10 = clamp(-fmul(k1, h0));
                    m11 = clamp(ONE - fmul(k1, h1));
                    x0 = clamp(x0 + fmul(k0, y));
                    x1 = clamp(x1 + fmul(k1, y));
                    n00 = clamp(fmul(m00, c00) + fmul(m01, c10));
                    n01 = clamp(fmul(m00, c01) + fmul(m01, c11));
                    n10 = clamp(fmul(m10, c00) + fmul(m11, c10));
                    n11 = clamp(fmul(m10, c01) + fmul(m11, c11));
                    c00 = n00; c01 = n01; c10 = n10; c11 = n11;
                end
                p = clamp(fmul(fa, x0) + fmul(fb, x1));
                v = clamp(fmul(fc, x0) + fmul(fd, x1));
                x0 = p; x1 = v;
                t00 = clamp(fmul(fa, c00) + fmul(fb, c10));
                t01 = clamp(fmul(fa, c01) + fmul(fb, c11));
                t10 = clamp(fmul(fc, c00) + fmul(fd, c10));
                t11 = clamp(fmul(fc, c01) + fmul(fd, c11));
                c00 = clamp(fmul(t00, fa) + fmul(t01, fb));
                c01 = clamp(fmul(t00, fc) + fmul(t01, fd));
                c10 = clamp(fmul(t10, fa) + fmul(t11, fb));
                c11 = clamp(fmul(t10, fc) + fmul(t11, fd));
                if (st == STAT_OK && sat) st = STAT_SAT;
            end
            e.pos = x0[31:0]; e.vel = x1[31:0];
            e.p00 = c00[31:0]; e.p01 = c01[31:0]; e.p10 = c10[31:0]; e.p11 = c11[31:0];
            e.status = st;
            pending.push_back(e);
        endfunction

        function void check_result(t_estimate got);
            t_estimate want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.pos !== want.pos) report("position", want.pos, got.pos);
            if (got.vel !== want.vel) report("velocity", want.vel, got.vel);
            if (got.p00 !== want.p00) report("var_pp", want.p00, got.p00);
            if (got.p01 !== want.p01) report("var_pv", want.p01, got.p01);
            if (got.p10 !== want.p10) report("var_vp", want.p10, got.p10);
            if (got.p11 !== want.p11) report("var_vv", want.p11, got.p11);
            if (got.status !== want.status) report("status", want.status, got.status);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
            errors++;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    kf2_in_if  meas_ch();
    kf2_out_if est_ch();

    kalman_filter_2state_scalar dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in(meas_ch.sink), .o_out(est_ch.source)
    );

    kf_scoreboard sb = new();

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    initial begin
        meas_ch.valid = 0;
        meas_ch.meas_value = '0;
        meas_ch.restart = 0;
        est_ch.ready = 0;
    end

    // Write one register: setup cycle then access cycle, driven at falling edges.
    task automatic write_reg(t_reg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= 5'(4 * int'(idx)); pwdata <= v;
        @(negedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    // Send one measurement or restart; the prediction is queued on acceptance.
    task automatic send_item(logic signed [31:0] z, logic rst);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        repeat (gap) @(negedge i_clk);
        meas_ch.valid <= 1;
        meas_ch.meas_value <= z;
        meas_ch.restart <= rst;
        do @(posedge i_clk); while (!meas_ch.ready);
        sb.note_input(z, rst);
        @(negedge i_clk);
        meas_ch.valid <= 0;
    endtask

    // Wait until every queued estimate has come back, then let the block settle.
    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_fix(int span);
        // mostly small values around zero, sometimes exactly one, sometimes anything
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'(ONE);
            default: return 32'($signed($urandom_range(0, 2 * span)) - span);
        endcase
    endfunction

    // Programme a random but mostly well-conditioned filter.
    task automatic random_config(int phase);
        int k;
        logic [31:0] v;
        for (k = 0; k < 8; k++) begin
            case (k)
                REG_TRANS_A, REG_TRANS_D: v = 32'(ONE) + rand_fix(4096);
                REG_TRANS_B:              v = rand_fix(65536);
                REG_TRANS_C:              v = rand_fix(2048);
                REG_OBS_POS:              v = 32'(ONE) + rand_fix(16384);
                REG_OBS_VEL:              v = rand_fix(8192);
                REG_MEAS_NOISE:           v = {1'b0, 31'($urandom_range(0, 32'h0010_0000))};
                default:                  v = {1'b0, 31'($urandom_range(0, 32'h0200_0000))};
            endcase
            if (phase % 5 == 4) v = (k < 6) ? $urandom : {1'b0, 31'($urandom)};
            write_reg(t_reg_idx'(k), v);
        end
    endtask

    // Result side: wait a random number of cycles per transaction, then take it.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            hold = $urandom_range(0, 16);
            repeat (hold) @(negedge i_clk);
            @(negedge i_clk);
            est_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!est_ch.valid);
            @(negedge i_clk);
            est_ch.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_estimate got;
        if (i_rst_n && est_ch.valid && est_ch.ready) begin
            got.pos = est_ch.est_position; got.vel = est_ch.est_velocity;
            got.p00 = est_ch.var_pp; got.p01 = est_ch.var_pv;
            got.p10 = est_ch.var_vp; got.p11 = est_ch.var_vv;
            got.status = est_ch.status;
            sb.check_result(got);
        end
    end

    initial begin
        int n, phase;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: defaults, extremes, skip and saturation
        send_item(32'sd0, 0);
        send_item(32'sh7fff_ffff, 0);
        send_item(-32'sh8000_0000, 0);
        send_item($urandom, 1);
        send_item(32'sd65536, 0);
        send_item(32'shffff_ffff, 0);
        drain();
        write_reg(REG_MEAS_NOISE, 32'h0000_0000);
        write_reg(REG_INIT_VAR, 32'h0000_0000);
        send_item(32'sd0, 1);
        send_item(32'sd12345, 0);             // S of zero: update skipped
        drain();
        write_reg(REG_OBS_POS, 32'h8000_0000);
        write_reg(REG_OBS_VEL, 32'h7fff_ffff);
        write_reg(REG_INIT_VAR, 32'h7fff_ffff);
        write_reg(REG_MEAS_NOISE, 32'h7fff_ffff);
        send_item(32'sd0, 1);
        send_item(32'sh7fff_ffff, 0);
        send_item(-32'sh8000_0000, 0);
        drain();
        write_reg(REG_TRANS_A, 32'h7fff_ffff);
        write_reg(REG_TRANS_B, 32'h8000_0000);
        write_reg(REG_TRANS_C, 32'h7fff_ffff);
        write_reg(REG_TRANS_D, 32'h8000_0000);
        write_reg(REG_OBS_VEL, 32'hffff_ffff);
        send_item(32'sh4000_0000, 0);
        send_item(32'sh7fff_ffff, 0);
        send_item(32'sd0, 1);
        send_item(-32'sd1, 0);
        drain();

        // random phases: a restart, then a run of measurements with random content and occasional restarts
        for (phase = 0; phase < 19; phase++) begin
            random_config(phase);
            send_item($urandom, 1);
            for (n = 0; n < 100; n++) begin
                if ($urandom_range(0, 30) == 0)
                    send_item($urandom, 1);
                else if ($urandom_range(0, 7) == 0)
                    send_item($urandom, 0);
                else
                    send_item(32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000),
                              0);
            end
            drain();
        end

        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #50ms;
        $display("tb_top: FAIL");
        $finish;
    end
endmodule
